// File: hw/rtl/wpd_pkg.sv
`default_nettype none

package wpd_pkg;

  // Default sizes of the weight table
  localparam int DEF_ENTRY_COUNT = 16;
  localparam int DEF_WEIGHT_BITS = 8;

  // Field widths on the ports
  localparam int IDX_W      = 4;
  localparam int WVAL_W     = 8;
  localparam int DRAW_W     = 12;
  localparam int TOTAL_W    = 12;
  localparam int DECAY_W    = 8;
  localparam int IN_USE_W   = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Packed stream payloads
  localparam int IN_DATA_W  = IDX_W + WVAL_W + DRAW_W;
  localparam int OUT_DATA_W = IDX_W + WVAL_W + TOTAL_W;

  // Reset values and limits
  localparam int RESET_WEIGHT = 50;
  localparam int RESET_DECAY  = 10;
  localparam int RESET_IN_USE = 5;
  localparam int TOTAL_MAX    = 4095;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_USE = 1'b1;

  // Request kinds
  typedef enum logic {
    OP_PICK  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_WALK,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/wpd_table.sv
`default_nettype none

module wpd_table #(
  parameter int ENTRY_COUNT = wpd_pkg::DEF_ENTRY_COUNT,
  parameter int WEIGHT_BITS = wpd_pkg::DEF_WEIGHT_BITS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  rd_en,
  input  wire logic [$clog2(ENTRY_COUNT)-1:0]        rd_addr,
  output logic      [WEIGHT_BITS-1:0]                rd_data,
  input  wire logic                                  wr_en,
  input  wire logic [$clog2(ENTRY_COUNT)-1:0]        wr_addr,
  input  wire logic [WEIGHT_BITS-1:0]                wr_data
);
  import wpd_pkg::*;

  localparam logic [WEIGHT_BITS-1:0] WMAX = {WEIGHT_BITS{1'b1}};
  localparam logic [WEIGHT_BITS-1:0] RESET_W =
    (RESET_WEIGHT > int'(WMAX)) ? WMAX : WEIGHT_BITS'(RESET_WEIGHT);

  logic [WEIGHT_BITS-1:0] mem [ENTRY_COUNT];
  logic [ENTRY_COUNT-1:0] vld;
  logic [WEIGHT_BITS-1:0] mem_q;
  logic                   vld_q;

  // Write port; untouched entries read as the reset weight
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
      vld_q <= vld[rd_addr];
    end
  end

  assign rd_data = vld_q ? mem_q : RESET_W;

endmodule

`default_nettype wire

// File: hw/rtl/weighted_pick_with_decay_top.sv
// Sequence: a request first sums the weights of the N entries in use, and a pick then
// walks the prefix sums to the drawn entry; a write or a pick with no hit skips the walk.
// Throughput: one request at a time, the next taken only after the result is loaded into
// the output register; the single read port of the weight memory sets the
// pace, one weight per cycle in the sum pass and in the prefix walk.
// Reset: synchronous; all weights read as 50, decay 10, five entries in use.
`default_nettype none

module weighted_pick_with_decay_top #(
  parameter int ENTRY_COUNT = wpd_pkg::DEF_ENTRY_COUNT,
  parameter int WEIGHT_BITS = wpd_pkg::DEF_WEIGHT_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // request stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [3:0] entry_index, [11:4] weight_value, [23:12] draw
  input  wire logic [wpd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [0] op
  input  wire logic                              s_axis_tuser,
  // result stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [3:0] picked_index, [11:4] weight_after, [23:12] total_weight
  output logic      [wpd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // [0] picked
  output logic                                   m_axis_tuser,
  // configuration writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [wpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [wpd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import wpd_pkg::*;

  localparam int AW    = $clog2(ENTRY_COUNT);
  localparam int CW    = $clog2(ENTRY_COUNT + 1);
  localparam int SW    = WEIGHT_BITS + $clog2(ENTRY_COUNT);
  localparam int CMPW  = (SW > DRAW_W) ? SW : DRAW_W;
  localparam int DW    = (WEIGHT_BITS > DECAY_W) ? WEIGHT_BITS : DECAY_W;
  localparam int IXW   = (AW > IDX_W) ? AW : IDX_W;
  localparam logic [WEIGHT_BITS-1:0] WMAX = {WEIGHT_BITS{1'b1}};

  // Configuration registers
  logic [DECAY_W-1:0]  decay_amount;
  logic [IN_USE_W-1:0] entries_in_use;

  // Sequencer and request registers
  state_t state, state_next;
  op_t                 op_q;
  logic [IDX_W-1:0]    idx_q;
  logic [WVAL_W-1:0]   val_q;
  logic [DRAW_W-1:0]   draw_q;
  logic [CW-1:0]       cnt;
  logic                pend;
  logic [SW-1:0]       acc;
  logic [SW-1:0]       total;

  // Result registers
  logic                   res_picked;
  logic [AW-1:0]          res_idx;
  logic [WEIGHT_BITS-1:0] res_w;

  // Output register
  logic                   out_valid;
  logic [OUT_DATA_W-1:0]  out_data;
  logic                   out_picked;

  // Combinational control
  logic                   in_fire;
  logic                   issue;
  logic                   out_load;
  logic [CW-1:0]          n_act;
  logic [WEIGHT_BITS-1:0] rd_w;
  logic [SW-1:0]          acc_new;
  logic                   hit;
  logic                   sum_done;
  logic                   pick_ok;
  logic                   idx_ok;
  logic [IXW-1:0]         idx_ext;
  logic [AW-1:0]          ret_addr;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [WEIGHT_BITS-1:0] wr_data;
  logic [WEIGHT_BITS-1:0] w_decayed;
  logic [WEIGHT_BITS-1:0] w_sat;
  logic [DW-1:0]          w_ext;
  logic [DW-1:0]          d_ext;
  logic [CMPW-1:0]        draw_ext;
  logic [CMPW-1:0]        total_ext;
  logic [TOTAL_W-1:0]     total_sat;

  assign cfg_ready = 1'b1;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      decay_amount   <= DECAY_W'(RESET_DECAY);
      entries_in_use <= IN_USE_W'(RESET_IN_USE);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DECAY:  decay_amount   <= cfg_data[DECAY_W-1:0];
        CFG_IN_USE: entries_in_use <= cfg_data[IN_USE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the active count to the table size
  assign n_act = (32'(entries_in_use) > 32'(ENTRY_COUNT)) ? CW'(ENTRY_COUNT)
                                                           : CW'(entries_in_use);

  // Weight memory
  wpd_table #(
    .ENTRY_COUNT(ENTRY_COUNT),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (issue),
    .rd_addr (cnt[AW-1:0]),
    .rd_data (rd_w),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Running sum, prefix hit and decay
  always_comb begin
    acc_new   = acc + SW'(rd_w);
    draw_ext  = CMPW'(draw_q);
    total_ext = CMPW'(acc);
    hit       = (state == ST_WALK) && pend && (draw_ext <= CMPW'(acc_new));
    sum_done  = (state == ST_SUM) && (cnt == n_act) && !pend;
    pick_ok   = (acc != '0) && (draw_q != '0) && (draw_ext <= total_ext);
    w_ext     = DW'(rd_w);
    d_ext     = DW'(decay_amount);
    w_decayed = (w_ext > d_ext) ? WEIGHT_BITS'(w_ext - d_ext) : '0;
    ret_addr  = AW'(cnt - CW'(1));
    idx_ext   = IXW'(idx_q);
    idx_ok    = 32'(idx_q) < 32'(ENTRY_COUNT);
    w_sat     = (32'(val_q) > 32'(WMAX)) ? WMAX : WEIGHT_BITS'(val_q);
    wr_en     = hit || (sum_done && (op_q == OP_WRITE) && idx_ok);
    wr_addr   = hit ? ret_addr : idx_ext[AW-1:0];
    wr_data   = hit ? w_decayed : w_sat;
    total_sat = (CMPW'(total) > CMPW'(TOTAL_MAX)) ? TOTAL_W'(TOTAL_MAX)
                                                   : TOTAL_W'(total);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_axis_tvalid) state_next = ST_SUM;
      ST_SUM: begin
        if (sum_done) begin
          state_next = ((op_q == OP_PICK) && pick_ok) ? ST_WALK : ST_OUT;
        end
      end
      ST_WALK: begin
        if (hit || ((cnt == n_act) && !pend)) state_next = ST_OUT;
      end
      ST_OUT: if (!out_valid || m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    issue         = ((state == ST_SUM) || (state == ST_WALK)) && (cnt < n_act) && !hit;
    out_load      = (state == ST_OUT) && (!out_valid || m_axis_tready);
    in_fire       = s_axis_tvalid && s_axis_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= issue;
    end
  end

  // Request capture, read sweeps and result capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q   <= op_t'(s_axis_tuser);
      idx_q  <= s_axis_tdata[IDX_W-1:0];
      val_q  <= s_axis_tdata[IDX_W +: WVAL_W];
      draw_q <= s_axis_tdata[IDX_W+WVAL_W +: DRAW_W];
      cnt    <= '0;
      acc    <= '0;
    end else if (sum_done) begin
      total      <= acc;
      acc        <= '0;
      cnt        <= '0;
      res_picked <= 1'b0;
      res_idx    <= '0;
      res_w      <= '0;
    end else begin
      if (issue) cnt <= cnt + CW'(1);
      if (pend)  acc <= acc_new;
      if (hit) begin
        res_picked <= 1'b1;
        res_idx    <= ret_addr;
        res_w      <= w_decayed;
      end
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_picked <= res_picked;
      out_data   <= {total_sat, WVAL_W'(res_w), IDX_W'(res_idx)};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_picked;

endmodule

`default_nettype wire

// File: hw/rtl/wpd_checker.sv
`default_nettype none

module wpd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [23:0] s_axis_tdata,
  input wire logic        s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  // Ready to take a request right after reset
  a_ready_after_reset: assert property (@(posedge clk) rst |=> s_axis_tready)
    else $error("request side not ready after reset");

  // One request at a time: no request taken on the cycle after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("two requests taken back to back");

  // Without a pick, index and weight read zero
  a_no_pick_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[11:0] == 12'd0))
    else $error("non-pick result carries index or weight");

  // A pick needs a nonzero total
  a_pick_total: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[23:12] != 12'd0))
    else $error("pick reported with zero total");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind weighted_pick_with_decay_top wpd_checker u_wpd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
